// ----- hdl/clt_pkg.sv -----
// Shared types, constants, character classes and the keyword table of the line classifier.
package clt_pkg;

    localparam int CP_W    = 16;
    localparam int START_W = 12;
    localparam int LEN_W   = 13;
    localparam int CLS_W   = 3;

    localparam int DEF_MAX_LINE        = 4096;
    localparam int DEF_MAX_SPANS       = 255;
    localparam int DEF_KEYWORD_MAX_LEN = 9;

    // span queue between lexer and output side
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    typedef enum logic [3:0] {
        LM_IDLE,
        LM_WS,
        LM_LCOMM,
        LM_BCOMM,
        LM_STR,
        LM_CHR,
        LM_NUM,
        LM_WORD,
        LM_TAIL
    } t_lex_mode;

    localparam logic [CLS_W-1:0] CLS_TEXT    = 3'd0;
    localparam logic [CLS_W-1:0] CLS_COMMENT = 3'd1;
    localparam logic [CLS_W-1:0] CLS_STRING  = 3'd2;
    localparam logic [CLS_W-1:0] CLS_CHAR    = 3'd3;
    localparam logic [CLS_W-1:0] CLS_NUMBER  = 3'd4;
    localparam logic [CLS_W-1:0] CLS_IDENT   = 3'd5;
    localparam logic [CLS_W-1:0] CLS_KEYWORD = 3'd6;
    localparam logic [CLS_W-1:0] CLS_PUNCT   = 3'd7;

    localparam logic [CP_W-1:0] CH_SLASH  = 16'h002F;
    localparam logic [CP_W-1:0] CH_STAR   = 16'h002A;
    localparam logic [CP_W-1:0] CH_DQUOTE = 16'h0022;
    localparam logic [CP_W-1:0] CH_SQUOTE = 16'h0027;
    localparam logic [CP_W-1:0] CH_BSLASH = 16'h005C;
    localparam logic [CP_W-1:0] CH_DOT    = 16'h002E;
    localparam logic [CP_W-1:0] CH_ASCII_MAX = 16'h007F;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic [CLS_W-1:0]   cls;
        logic               run_last;
        logic               line_final;
    } t_span;

    // all spans caused by one character, one to three
    typedef struct packed {
        logic [1:0]       count;
        t_span [2:0]      spans;
    } t_bundle;

    localparam int KW_COUNT = 45;
    localparam int KW_SLOTS = 9;

    localparam logic [8*KW_SLOTS-1:0] KW_TEXT [KW_COUNT] = '{
        "auto", "break", "case", "char", "const", "continue", "default", "do",
        "double", "else", "enum", "extern", "float", "for", "goto", "if",
        "inline", "int", "long", "register", "restrict", "return", "short",
        "signed", "sizeof", "static", "struct", "switch", "typedef", "union",
        "unsigned", "void", "volatile", "while", "class", "namespace", "template",
        "typename", "using", "new", "delete", "bool", "true", "false", "nullptr"
    };

    localparam int KW_LEN [KW_COUNT] = '{
        4, 5, 4, 4, 5, 8, 7, 2,
        6, 4, 4, 6, 5, 3, 4, 2,
        6, 3, 4, 8, 8, 6, 5,
        6, 6, 6, 6, 6, 7, 5,
        8, 4, 8, 5, 5, 9, 8,
        8, 5, 3, 6, 4, 4, 5, 7
    };

    function automatic logic is_space(input logic [CP_W-1:0] c);
        return (c == 16'd32) || (c >= 16'd9 && c <= 16'd13);
    endfunction

    function automatic logic is_digit(input logic [CP_W-1:0] c);
        return (c >= 16'h0030) && (c <= 16'h0039);
    endfunction

    function automatic logic is_word(input logic [CP_W-1:0] c);
        return is_digit(c) || (c >= 16'h0061 && c <= 16'h007A) ||
               (c >= 16'h0041 && c <= 16'h005A) || (c == 16'h005F) ||
               (c > CH_ASCII_MAX);
    endfunction

endpackage

// ----- hdl/clt_front.sv -----
// Lexer front end: takes one character per transaction, updates lexer state, bundles closed spans.
module clt_front #(
    parameter int MAX_LINE        = 4096,
    parameter int MAX_SPANS       = 255,
    parameter int KEYWORD_MAX_LEN = 9
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_take,
    input  logic [15:0]            i_code_point,
    input  logic                   i_line_end,
    output logic                   o_push,
    output clt_pkg::t_bundle       o_bundle
);
    import clt_pkg::*;

    localparam int PW  = $clog2(MAX_LINE + 1);
    localparam int SW  = $clog2(MAX_SPANS + 1);
    localparam int KIW = $clog2(KEYWORD_MAX_LEN);

    localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_LINE);
    localparam logic [PW-1:0] KW_LIMIT  = PW'(KEYWORD_MAX_LEN);
    localparam logic [SW-1:0] CNT_LAST  = SW'(MAX_SPANS - 1);

    t_lex_mode      r_mode, n_mode;
    logic [PW-1:0]  r_begin, n_begin;
    logic [PW-1:0]  r_pos, n_pos;
    logic [SW-1:0]  r_cnt, n_cnt;
    logic           r_kp, n_kp;
    logic           r_esc, n_esc;
    logic           r_star, n_star;
    logic           r_slash, n_slash;
    logic [6:0]     r_wbuf [KEYWORD_MAX_LEN];
    logic [6:0]     n_wbuf [KEYWORD_MAX_LEN];

    logic [CP_W-1:0]  cp;
    logic [PW-1:0]    len_c;
    logic [PW-1:0]    f_len;
    logic [CLS_W-1:0] f_cls;
    logic             f_req;
    logic             do_start;
    logic             tailed;
    t_span [2:0]      em;
    logic [1:0]       em_n;

    // exact-length match of the buffered word against the keyword table
    function automatic logic kw_match(input logic [6:0] wb [KEYWORD_MAX_LEN],
                                      input logic [PW-1:0] len,
                                      input logic kp);
        logic any;
        logic hit;
        any = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            hit = (len == PW'(KW_LEN[k]));
            for (int j = 0; j < KW_SLOTS; j++) begin
                if (j < KW_LEN[k]) begin
                    hit = hit && (wb[j] == KW_TEXT[k][8*(KW_LEN[k]-1-j) +: 7]);
                end
            end
            any = any || hit;
        end
        return kp && any;
    endfunction

    assign cp = i_code_point;

    always_comb begin
        n_mode   = r_mode;
        n_begin  = r_begin;
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_kp     = r_kp;
        n_esc    = r_esc;
        n_star   = r_star;
        n_slash  = r_slash;
        n_wbuf   = r_wbuf;
        em       = '0;
        em_n     = 2'd0;
        do_start = 1'b0;
        tailed   = 1'b0;
        f_req    = 1'b0;
        f_cls    = CLS_TEXT;
        f_len    = '0;
        len_c    = r_pos - r_begin;

        if (r_pos < POS_LIMIT) begin
            if (r_mode != LM_TAIL) begin
                if (r_slash) begin
                    n_slash = 1'b0;
                    if (cp == CH_SLASH) begin
                        n_mode = LM_LCOMM;
                    end else if (cp == CH_STAR) begin
                        n_mode = LM_BCOMM;
                        n_star = 1'b0;
                    end else begin
                        // lone slash is punctuation
                        em[em_n] = '{START_W'(r_begin), LEN_W'(1), CLS_PUNCT, 1'b0, 1'b0};
                        em_n     = em_n + 2'd1;
                        tailed   = (n_cnt == CNT_LAST);
                        n_cnt    = n_cnt + 1'b1;
                        n_mode   = tailed ? LM_TAIL : LM_IDLE;
                        if (tailed) n_begin = r_pos;
                        do_start = !tailed;
                    end
                end else begin
                    f_req = 1'b0;
                    case (r_mode)
                        LM_WS: begin
                            if (!is_space(cp)) begin
                                f_req = 1'b1;
                                f_cls = CLS_TEXT;
                                f_len = len_c;
                            end
                        end
                        LM_LCOMM: begin
                        end
                        LM_BCOMM: begin
                            if (r_star && cp == CH_SLASH) begin
                                n_star = 1'b0;
                                em[em_n] = '{START_W'(r_begin), LEN_W'(PW'(len_c + 1'b1)),
                                             CLS_COMMENT, 1'b0, 1'b0};
                                em_n     = em_n + 2'd1;
                                tailed   = (n_cnt == CNT_LAST);
                                n_cnt    = n_cnt + 1'b1;
                                n_mode   = tailed ? LM_TAIL : LM_IDLE;
                                if (tailed) n_begin = PW'(r_pos + 1'b1);
                            end else begin
                                n_star = (cp == CH_STAR);
                            end
                        end
                        LM_STR, LM_CHR: begin
                            if (r_esc) begin
                                n_esc = 1'b0;
                            end else if (cp == CH_BSLASH) begin
                                n_esc = 1'b1;
                            end else if (cp == ((r_mode == LM_STR) ? CH_DQUOTE : CH_SQUOTE)) begin
                                em[em_n] = '{START_W'(r_begin), LEN_W'(PW'(len_c + 1'b1)),
                                             (r_mode == LM_STR) ? CLS_STRING : CLS_CHAR,
                                             1'b0, 1'b0};
                                em_n     = em_n + 2'd1;
                                tailed   = (n_cnt == CNT_LAST);
                                n_cnt    = n_cnt + 1'b1;
                                n_mode   = tailed ? LM_TAIL : LM_IDLE;
                                if (tailed) n_begin = PW'(r_pos + 1'b1);
                            end
                        end
                        LM_NUM: begin
                            if (!(is_word(cp) || cp == CH_DOT)) begin
                                f_req = 1'b1;
                                f_cls = CLS_NUMBER;
                                f_len = len_c;
                            end
                        end
                        LM_WORD: begin
                            if (is_word(cp)) begin
                                if (cp > CH_ASCII_MAX || len_c >= KW_LIMIT) begin
                                    n_kp = 1'b0;
                                end else begin
                                    n_wbuf[len_c[KIW-1:0]] = cp[6:0];
                                end
                            end else begin
                                f_req = 1'b1;
                                f_cls = kw_match(r_wbuf, len_c, r_kp) ? CLS_KEYWORD : CLS_IDENT;
                                f_len = len_c;
                            end
                        end
                        default: begin
                            do_start = 1'b1;
                        end
                    endcase
                    // span closed by the character that starts the next one
                    if (f_req) begin
                        em[em_n] = '{START_W'(r_begin), LEN_W'(f_len), f_cls, 1'b0, 1'b0};
                        em_n     = em_n + 2'd1;
                        tailed   = (n_cnt == CNT_LAST);
                        n_cnt    = n_cnt + 1'b1;
                        n_slash  = 1'b0;
                        n_mode   = tailed ? LM_TAIL : LM_IDLE;
                        if (tailed) n_begin = r_pos;
                        do_start = !tailed;
                    end
                end

                if (do_start) begin
                    n_begin = r_pos;
                    n_esc   = 1'b0;
                    if (is_space(cp)) begin
                        n_mode = LM_WS;
                    end else if (cp == CH_SLASH) begin
                        n_slash = 1'b1;
                    end else if (cp == CH_DQUOTE) begin
                        n_mode = LM_STR;
                    end else if (cp == CH_SQUOTE) begin
                        n_mode = LM_CHR;
                    end else if (is_digit(cp)) begin
                        n_mode = LM_NUM;
                    end else if (is_word(cp)) begin
                        n_mode = LM_WORD;
                        n_kp   = 1'b1;
                        if (cp > CH_ASCII_MAX) begin
                            n_kp = 1'b0;
                        end else begin
                            n_wbuf[0] = cp[6:0];
                        end
                    end else begin
                        em[em_n] = '{START_W'(r_pos), LEN_W'(1), CLS_PUNCT, 1'b0, 1'b0};
                        em_n     = em_n + 2'd1;
                        tailed   = (n_cnt == CNT_LAST);
                        n_cnt    = n_cnt + 1'b1;
                        n_slash  = 1'b0;
                        n_mode   = tailed ? LM_TAIL : LM_IDLE;
                        if (tailed) n_begin = PW'(r_pos + 1'b1);
                    end
                end
            end
            n_pos = PW'(r_pos + 1'b1);
        end

        if (i_line_end) begin
            // flush the open span, then the tail, then an empty marker if needed
            f_req = 1'b0;
            f_len = n_pos - n_begin;
            if (n_mode != LM_TAIL) begin
                if (n_slash) begin
                    f_req = 1'b1;
                    f_cls = CLS_PUNCT;
                    f_len = PW'(1);
                end else begin
                    case (n_mode)
                        LM_WS: begin
                            f_req = 1'b1;
                            f_cls = CLS_TEXT;
                        end
                        LM_LCOMM, LM_BCOMM: begin
                            f_req = 1'b1;
                            f_cls = CLS_COMMENT;
                        end
                        LM_STR: begin
                            f_req = 1'b1;
                            f_cls = CLS_STRING;
                        end
                        LM_CHR: begin
                            f_req = 1'b1;
                            f_cls = CLS_CHAR;
                        end
                        LM_NUM: begin
                            f_req = 1'b1;
                            f_cls = CLS_NUMBER;
                        end
                        LM_WORD: begin
                            f_req = 1'b1;
                            f_cls = kw_match(n_wbuf, f_len, n_kp) ? CLS_KEYWORD : CLS_IDENT;
                        end
                        default: begin
                            f_req = 1'b0;
                        end
                    endcase
                end
            end
            if (f_req) begin
                if (em_n != 2'd3) begin
                    em[em_n] = '{START_W'(n_begin), LEN_W'(f_len), f_cls, 1'b0, 1'b0};
                    em_n     = em_n + 2'd1;
                end
                tailed = (n_cnt == CNT_LAST);
                n_cnt  = n_cnt + 1'b1;
                n_mode = tailed ? LM_TAIL : LM_IDLE;
                if (tailed) n_begin = n_pos;
            end
            if (n_mode == LM_TAIL && em_n != 2'd3) begin
                em[em_n] = '{START_W'(n_begin), LEN_W'(PW'(n_pos - n_begin)), CLS_TEXT,
                             1'b0, 1'b0};
                em_n     = em_n + 2'd1;
            end
            if (em_n == 2'd0) begin
                em[0] = '{START_W'(n_pos), LEN_W'(0), CLS_TEXT, 1'b0, 1'b0};
                em_n  = 2'd1;
            end
            em[2'(em_n - 2'd1)].line_final = 1'b1;

            n_mode  = LM_IDLE;
            n_begin = '0;
            n_pos   = '0;
            n_cnt   = '0;
            n_kp    = 1'b1;
            n_esc   = 1'b0;
            n_star  = 1'b0;
            n_slash = 1'b0;
        end

        if (em_n != 2'd0) begin
            em[2'(em_n - 2'd1)].run_last = 1'b1;
        end
    end

    assign o_push         = i_take && (em_n != 2'd0);
    assign o_bundle.count = em_n;
    assign o_bundle.spans = em;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= LM_IDLE;
            r_begin <= '0;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_kp    <= 1'b1;
            r_esc   <= 1'b0;
            r_star  <= 1'b0;
            r_slash <= 1'b0;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_begin <= n_begin;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_kp    <= n_kp;
            r_esc   <= n_esc;
            r_star  <= n_star;
            r_slash <= n_slash;
        end
    end

    // word characters; no reset, only read where written
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_wbuf <= n_wbuf;
        end
    end

endmodule

// ----- hdl/clt_queue.sv -----
// Small span-bundle FIFO between the lexer front end and the output side.
module clt_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  clt_pkg::t_bundle   i_data,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output clt_pkg::t_bundle   o_head
);
    import clt_pkg::*;

    t_bundle          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QCW-1:0]   r_cnt;
    logic             do_push, do_pop;

    assign do_push = i_push && (r_cnt != QCW'(QDEPTH));
    assign do_pop  = i_pop && (r_cnt != '0);
    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- hdl/clt_back.sv -----
// Output side: walks the spans of the head bundle into a registered output stage.
module clt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  clt_pkg::t_bundle   i_q_head,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output clt_pkg::t_span     o_span
);
    import clt_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       r_valid;
    t_span      r_span;
    logic       load;
    logic       last_of_bundle;

    assign load           = i_q_valid && (!r_valid || i_out_ready);
    assign last_of_bundle = (r_idx == 2'(i_q_head.count - 2'd1));
    assign o_q_pop        = load && last_of_bundle;

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = last_of_bundle ? 2'd0 : 2'(r_idx + 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_span <= i_q_head.spans[r_idx];
        end
    end

    assign o_out_valid = r_valid;
    assign o_span      = r_span;

endmodule

// ----- hdl/c_line_token_classifier.sv -----
// Top level of the C/C++ line classifier: lexer front end, span queue, output side.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_code_point[15:0], i_line_end
//  out     | output    | o_out_valid / i_out_ready  | o_span_start[11:0], o_span_length[12:0],
//          |           |                            | o_span_class[2:0], o_run_last,
//          |           |                            | o_line_final
//
// One character transaction per cycle while the queue has room. The lexer closes zero
// to three spans per character; they travel as one bundle through a 4-entry queue, and
// the output side sends one span per cycle while i_out_ready is high.
// Input ready drops only when the queue is full; a stalled output just fills the queue.
// Reset (i_rst_n low, synchronous) returns the lexer to the start of a line and empties
// the queue and output register; the word buffer holds no reset value.
module c_line_token_classifier #(
    parameter int MAX_LINE        = clt_pkg::DEF_MAX_LINE,
    parameter int MAX_SPANS       = clt_pkg::DEF_MAX_SPANS,
    parameter int KEYWORD_MAX_LEN = clt_pkg::DEF_KEYWORD_MAX_LEN
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [15:0]                 i_code_point,
    input  logic                        i_line_end,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [11:0]                 o_span_start,
    output logic [12:0]                 o_span_length,
    output logic [2:0]                  o_span_class,
    output logic                        o_run_last,
    output logic                        o_line_final
);
    import clt_pkg::*;

    logic    take;
    logic    push;
    t_bundle push_data;
    logic    q_full;
    logic    q_valid;
    t_bundle q_head;
    logic    q_pop;
    t_span   out_span;

    // an incoming transaction is taken whenever the queue can hold its bundle
    assign o_in_ready = !q_full;
    assign take       = i_in_valid && o_in_ready;

    clt_front #(
        .MAX_LINE        (MAX_LINE),
        .MAX_SPANS       (MAX_SPANS),
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_code_point (i_code_point),
        .i_line_end   (i_line_end),
        .o_push       (push),
        .o_bundle     (push_data)
    );

    clt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    clt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_span      (out_span)
    );

    assign o_span_start  = out_span.start;
    assign o_span_length = out_span.length;
    assign o_span_class  = out_span.cls;
    assign o_run_last    = out_span.run_last;
    assign o_line_final  = out_span.line_final;

`ifndef SYNTHESIS
    // the final span of a line is always the last span of its transaction
    a_final_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_final |-> o_run_last)
        else $error("line_final span without run_last");

    // a line end always produces at least one span
    a_line_end_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_line_end |-> push)
        else $error("line end produced no span");

    // the front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("span queue overflow");

    // a bundle never claims zero spans
    a_bundle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> push_data.count != 2'd0)
        else $error("empty span bundle pushed");
`endif

endmodule

// ----- verif/c_line_token_classifier_test.sv -----
// Self-checking testbench for the C/C++ line classifier: directed table, random lines, checks.
module c_line_token_classifier_test;
    import clt_pkg::*;

    // Limits of the block as built with its default parameters
    localparam int unsigned LINE_LIMIT = 4096;
    localparam int unsigned SPAN_LIMIT = 255;
    localparam int unsigned KW_MAXLEN  = 9;

    localparam logic [15:0] K_SLASH  = 16'h002F;
    localparam logic [15:0] K_STAR   = 16'h002A;
    localparam logic [15:0] K_DQUOTE = 16'h0022;
    localparam logic [15:0] K_SQUOTE = 16'h0027;
    localparam logic [15:0] K_BSLASH = 16'h005C;
    localparam logic [15:0] K_DOT    = 16'h002E;

    localparam string PUNCT_SET = "!#$%&()*+,-.:;<=>?@[]^{|}~\\";
    localparam string WORD_SET  =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

    string c_keywords [45] = '{
        "auto", "break", "case", "char", "const", "continue", "default", "do",
        "double", "else", "enum", "extern", "float", "for", "goto", "if",
        "inline", "int", "long", "register", "restrict", "return", "short",
        "signed", "sizeof", "static", "struct", "switch", "typedef", "union",
        "unsigned", "void", "volatile", "while", "class", "namespace", "template",
        "typename", "using", "new", "delete", "bool", "true", "false", "nullptr"
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_code_point;
    logic        i_line_end;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [11:0] o_span_start;
    logic [12:0] o_span_length;
    logic [2:0]  o_span_class;
    logic        o_run_last;
    logic        o_line_final;

    always #6 i_clk = ~i_clk;

    c_line_token_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_code_point  (i_code_point),
        .i_line_end    (i_line_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_span_start  (o_span_start),
        .o_span_length (o_span_length),
        .o_span_class  (o_span_class),
        .o_run_last    (o_run_last),
        .o_line_final  (o_line_final)
    );

    // ------------------------------------------------------------------
    // Lexer mirror: state of the line being split, updated per accepted
    // character, and the spans that each character closes.
    // ------------------------------------------------------------------
    t_lex_mode   lx_mode;
    int unsigned tok_begin;
    int unsigned col;
    int unsigned spans_closed;
    logic [7:0]  word_chars [KW_MAXLEN];
    bit          kw_ok;
    bit          esc_open;
    bit          star_last;
    bit          slash_held;

    t_span step_spans [$];  // spans closed by the current character
    t_span spans_due [$];   // spans the block still owes, oldest first

    int mismatches;
    int spans_checked;
    int chars_sent;
    int lines_sent;
    int burst_left;
    bit holdoff_pending;

    logic [15:0] line_buf [$];

    function automatic bit is_ws(logic [15:0] c);
        return c == 16'd32 || (c >= 16'd9 && c <= 16'd13);
    endfunction

    function automatic bit is_dig(logic [15:0] c);
        return c >= 16'h30 && c <= 16'h39;
    endfunction

    function automatic bit is_wordch(logic [15:0] c);
        return is_dig(c) || (c >= 16'h61 && c <= 16'h7A) || (c >= 16'h41 && c <= 16'h5A) ||
               c == 16'h5F || c > 16'd127;
    endfunction

    function automatic void emit_span(int unsigned s, int unsigned l, logic [2:0] c);
        t_span sp;
        sp = '0;
        sp.start  = s[11:0];
        sp.length = l[12:0];
        sp.cls    = c;
        if (step_spans.size() < 3) step_spans.push_back(sp);
    endfunction

    // Closes a counted span; returns 1 when the span limit turns the rest into text.
    function automatic bit close_span(int unsigned s, int unsigned l, logic [2:0] c,
                                      int unsigned nxt);
        emit_span(s, l, c);
        spans_closed++;
        slash_held = 1'b0;
        if (spans_closed >= SPAN_LIMIT) begin
            lx_mode   = LM_TAIL;
            tok_begin = nxt;
            return 1'b1;
        end
        lx_mode = LM_IDLE;
        return 1'b0;
    endfunction

    function automatic void word_push(logic [15:0] c, int unsigned idx);
        if (c > 16'd127 || idx >= KW_MAXLEN) kw_ok = 1'b0;
        else word_chars[idx] = c[7:0];
    endfunction

    function automatic bit keyword_hit(int unsigned len);
        string kw;
        bit    same;
        if (!kw_ok || len > KW_MAXLEN) return 1'b0;
        foreach (c_keywords[k]) begin
            kw = c_keywords[k];
            if (kw.len() == len) begin
                same = 1'b1;
                for (int j = 0; j < len; j++)
                    if (kw[j] != word_chars[j]) same = 1'b0;
                if (same) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void open_token(logic [15:0] c, int unsigned p);
        tok_begin = p;
        esc_open  = 1'b0;
        if (is_ws(c)) lx_mode = LM_WS;
        else if (c == K_SLASH) slash_held = 1'b1;
        else if (c == K_DQUOTE) lx_mode = LM_STR;
        else if (c == K_SQUOTE) lx_mode = LM_CHR;
        else if (is_dig(c)) lx_mode = LM_NUM;
        else if (is_wordch(c)) begin
            lx_mode = LM_WORD;
            kw_ok   = 1'b1;
            word_push(c, 0);
        end else
            void'(close_span(p, 1, CLS_PUNCT, p + 1));
    endfunction

    function automatic void take_char(logic [15:0] c, int unsigned p);
        int unsigned len;
        logic [15:0] q;
        logic [2:0]  qc;
        len = p - tok_begin;
        if (lx_mode == LM_TAIL) return;
        // a held '/' decides between comment and punctuation
        if (slash_held) begin
            slash_held = 1'b0;
            if (c == K_SLASH) begin
                lx_mode = LM_LCOMM;
                return;
            end
            if (c == K_STAR) begin
                lx_mode   = LM_BCOMM;
                star_last = 1'b0;
                return;
            end
            if (close_span(tok_begin, 1, CLS_PUNCT, p)) return;
            open_token(c, p);
            return;
        end
        case (lx_mode)
            LM_WS: begin
                if (is_ws(c)) return;
                if (close_span(tok_begin, len, CLS_TEXT, p)) return;
                open_token(c, p);
            end
            LM_LCOMM: ;
            LM_BCOMM: begin
                if (star_last && c == K_SLASH) begin
                    star_last = 1'b0;
                    void'(close_span(tok_begin, len + 1, CLS_COMMENT, p + 1));
                end else
                    star_last = (c == K_STAR);
            end
            LM_STR, LM_CHR: begin
                q  = (lx_mode == LM_STR) ? K_DQUOTE : K_SQUOTE;
                qc = (lx_mode == LM_STR) ? CLS_STRING : CLS_CHAR;
                if (esc_open) esc_open = 1'b0;
                else if (c == K_BSLASH) esc_open = 1'b1;
                else if (c == q) void'(close_span(tok_begin, len + 1, qc, p + 1));
            end
            LM_NUM: begin
                if (is_wordch(c) || c == K_DOT) return;
                if (close_span(tok_begin, len, CLS_NUMBER, p)) return;
                open_token(c, p);
            end
            LM_WORD: begin
                if (is_wordch(c)) begin
                    word_push(c, len);
                    return;
                end
                if (close_span(tok_begin, len, keyword_hit(len) ? CLS_KEYWORD : CLS_IDENT, p))
                    return;
                open_token(c, p);
            end
            default: open_token(c, p);
        endcase
    endfunction

    // Line end: close whatever is open, then the tail text, and make sure
    // something carries the line-final mark.
    function automatic void end_line();
        int unsigned n;
        int unsigned len;
        t_span       sp;
        n   = col;
        len = n - tok_begin;
        if (lx_mode != LM_TAIL) begin
            if (slash_held)
                void'(close_span(tok_begin, 1, CLS_PUNCT, n));
            else begin
                case (lx_mode)
                    LM_WS:              void'(close_span(tok_begin, len, CLS_TEXT, n));
                    LM_LCOMM, LM_BCOMM: void'(close_span(tok_begin, len, CLS_COMMENT, n));
                    LM_STR:             void'(close_span(tok_begin, len, CLS_STRING, n));
                    LM_CHR:             void'(close_span(tok_begin, len, CLS_CHAR, n));
                    LM_NUM:             void'(close_span(tok_begin, len, CLS_NUMBER, n));
                    LM_WORD: void'(close_span(tok_begin, len,
                                              keyword_hit(len) ? CLS_KEYWORD : CLS_IDENT, n));
                    default: ;
                endcase
            end
        end
        if (lx_mode == LM_TAIL) emit_span(tok_begin, n - tok_begin, CLS_TEXT);
        if (step_spans.size() == 0) emit_span(n, 0, CLS_TEXT);
        sp = step_spans.pop_back();
        sp.line_final = 1'b1;
        step_spans.push_back(sp);
    endfunction

    function automatic void line_reset();
        lx_mode      = LM_IDLE;
        tok_begin    = 0;
        col          = 0;
        spans_closed = 0;
        kw_ok        = 1'b1;
        esc_open     = 1'b0;
        star_last    = 1'b0;
        slash_held   = 1'b0;
    endfunction

    function automatic void classify_char(logic [15:0] c, logic le);
        t_span sp;
        step_spans.delete();
        // characters past the line limit only contribute their end mark
        if (col < LINE_LIMIT) begin
            take_char(c, col);
            col++;
        end
        if (le) begin
            end_line();
            line_reset();
        end
        if (step_spans.size() > 0) begin
            sp = step_spans.pop_back();
            sp.run_last = 1'b1;
            step_spans.push_back(sp);
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: every span transaction is held against the oldest due span.
    // ------------------------------------------------------------------
    task automatic check_span();
        t_span want;
        if (spans_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected span start %0d len %0d class %0d last %0b final %0b",
                         $realtime, o_span_start, o_span_length, o_span_class, o_run_last,
                         o_line_final);
        end else begin
            want = spans_due.pop_front();
            spans_checked++;
            if (want.start !== o_span_start || want.length !== o_span_length ||
                want.cls !== o_span_class || want.run_last !== o_run_last ||
                want.line_final !== o_line_final) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: span differs, want %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                             $realtime, want.start, want.length, want.cls, want.run_last,
                             want.line_final, o_span_start, o_span_length, o_span_class,
                             o_run_last, o_line_final);
            end
        end
    endtask

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && i_out_ready) check_span();

    // ------------------------------------------------------------------
    // Input side: bursts of characters with random gaps between them.
    // ------------------------------------------------------------------
    task automatic drive_char(input logic [15:0] c, input logic le, input bit use_typed,
                              input t_span typed);
        int gap;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 160)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_code_point <= c;
        i_line_end   <= le;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // transaction taken at this edge
        classify_char(c, le);
        if (use_typed) spans_due.push_back(typed);
        else foreach (step_spans[i]) spans_due.push_back(step_spans[i]);
        chars_sent++;
        if (le) lines_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_line();
        foreach (line_buf[i]) drive_char(line_buf[i], i == line_buf.size() - 1, 1'b0, '0);
    endtask

    // Sender stops offering until the block owes nothing.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (spans_due.size() != 0) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Line builders
    // ------------------------------------------------------------------
    function automatic logic [15:0] rand_cp(int unsigned lo, int unsigned hi);
        logic [31:0] v;
        v = $urandom_range(hi, lo);
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_from(string s);
        int r;
        r = $urandom_range(0, s.len() - 1);
        return {8'h00, s[r]};
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back({8'h00, s[i]});
    endfunction

    // string or char literal, sometimes with escapes, sometimes left open
    function automatic void add_quoted(logic [15:0] q);
        logic [15:0] c;
        line_buf.push_back(q);
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 4) == 0) begin
                line_buf.push_back(K_BSLASH);
                line_buf.push_back(rand_cp(32, 126));
            end else begin
                do c = rand_cp(32, 126); while (c == q || c == K_BSLASH);
                line_buf.push_back(c);
            end
        end
        if ($urandom_range(0, 7) != 0) line_buf.push_back(q);
    endfunction

    function automatic void add_fragment();
        case ($urandom_range(0, 12))
            0: begin
                add_str(c_keywords[$urandom_range(0, 44)]);
                // near misses: longer word or changed last letter
                case ($urandom_range(0, 5))
                    0: line_buf.push_back(pick_from(WORD_SET));
                    1: begin
                        void'(line_buf.pop_back());
                        line_buf.push_back(pick_from(WORD_SET));
                    end
                    default: ;
                endcase
            end
            1: begin
                line_buf.push_back(($urandom_range(0, 7) == 0) ? rand_cp(128, 65535)
                                                               : pick_from("abcxyzXQ_"));
                repeat ($urandom_range(0, 11))
                    line_buf.push_back(($urandom_range(0, 15) == 0) ? rand_cp(128, 65535)
                                                                    : pick_from(WORD_SET));
            end
            2: begin
                line_buf.push_back(rand_cp(16'h30, 16'h39));
                repeat ($urandom_range(0, 5)) line_buf.push_back(pick_from("0123456789.xeEfuL"));
            end
            3: repeat ($urandom_range(1, 4)) line_buf.push_back(pick_from("\t\n\v\f\r    "));
            4: add_quoted(K_DQUOTE);
            5: add_quoted(K_SQUOTE);
            6: begin
                add_str("//");
                repeat ($urandom_range(0, 10)) line_buf.push_back(rand_cp(32, 126));
            end
            7: begin
                add_str("/*");
                repeat ($urandom_range(0, 8)) line_buf.push_back(pick_from("ab */x*/"));
                if ($urandom_range(0, 3) != 0) add_str("*/");
            end
            8, 12: line_buf.push_back(pick_from(PUNCT_SET));
            9: begin
                line_buf.push_back(K_SLASH);
                line_buf.push_back(pick_from("ab9;= (\"'"));
            end
            10: line_buf.push_back(rand_cp(0, 65535));
            default: line_buf.push_back(rand_cp(128, 65535));
        endcase
    endfunction

    function automatic void build_random_line();
        line_buf.delete();
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 8)) line_buf.push_back(rand_cp(0, 65535));
        else begin
            repeat ($urandom_range(1, 6)) add_fragment();
            // escape as the very last character of the line
            if ($urandom_range(0, 11) == 0) add_str("\"a\\");
        end
    endfunction

    // Lines around the span limit; variant 1 closes three spans on its last character.
    function automatic void build_span_limit_line(int v);
        line_buf.delete();
        repeat (252 + v) line_buf.push_back(pick_from(PUNCT_SET));
        add_str(" ;");
        if (v >= 2) add_str("x1 y");
    endfunction

    // ------------------------------------------------------------------
    // Directed table: short lines and line fragments. Where the single
    // result is obvious it is typed in, else the mirror supplies it.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [15:0] cp;
        logic        le;
        logic        typed;
        logic [11:0] s;
        logic [12:0] l;
        logic [2:0]  c;
    } t_stim_row;

    t_stim_row opening_rows [24] = '{
        '{"x",      1'b1, 1'b1, 12'd0, 13'd1, CLS_IDENT},   // one-letter line
        '{";",      1'b1, 1'b1, 12'd0, 13'd1, CLS_PUNCT},
        '{16'hFFFF, 1'b1, 1'b1, 12'd0, 13'd1, CLS_IDENT},   // top code point is a word char
        '{16'h0000, 1'b1, 1'b1, 12'd0, 13'd1, CLS_PUNCT},   // NUL is punctuation
        '{" ",      1'b1, 1'b1, 12'd0, 13'd1, CLS_TEXT},
        '{"/",      1'b1, 1'b1, 12'd0, 13'd1, CLS_PUNCT},   // held slash released at line end
        '{"/",      1'b0, 1'b0, 12'd0, 13'd0, CLS_TEXT},    // "/*/": opener star cannot close,
        '{"*",      1'b0, 1'b0, 12'd0, 13'd0, CLS_TEXT},    //   comment runs to the line end
        '{"/",      1'b1, 1'b0, 12'd0, 13'd0, CLS_TEXT},
        '{"i",      1'b0, 1'b0, 12'd0, 13'd0, CLS_TEXT},    // "if(": keyword and punct together
        '{"f",      1'b0, 1'b0, 12'd0, 13'd0, CLS_TEXT},
        '{"(",      1'b1, 1'b0, 12'd0, 13'd0, CLS_TEXT},
        '{"\"",     1'b0, 1'b0, 12'd0, 13'd0, CLS_TEXT},    // escape on the last character
        '{"\\",     1'b1, 1'b0, 12'd0, 13'd0, CLS_TEXT},
        '{"'",      1'b0, 1'b0, 12'd0, 13'd0, CLS_TEXT},    // escaped quote leaves char open
        '{"\\",     1'b0, 1'b0, 12'd0, 13'd0, CLS_TEXT},
        '{"'",      1'b1, 1'b0, 12'd0, 13'd0, CLS_TEXT},
        '{"9",      1'b0, 1'b0, 12'd0, 13'd0, CLS_TEXT},    // number takes the dot
        '{".",      1'b0, 1'b0, 12'd0, 13'd0, CLS_TEXT},
        '{"+",      1'b1, 1'b0, 12'd0, 13'd0, CLS_TEXT},
        '{"/",      1'b0, 1'b0, 12'd0, 13'd0, CLS_TEXT},    // line comment
        '{"/",      1'b0, 1'b0, 12'd0, 13'd0, CLS_TEXT},
        '{"~",      1'b1, 1'b0, 12'd0, 13'd0, CLS_TEXT},
        '{16'h8000, 1'b1, 1'b1, 12'd0, 13'd1, CLS_IDENT}
    };

    // ------------------------------------------------------------------
    // Receiver: phases of steady, random and periodic stalls, plus one
    // long hold-off on request that lets the span queue fill up.
    // ------------------------------------------------------------------
    initial begin
        int rx_phase;
        int rx_left;
        int rx_tick;
        int hold_n;
        rx_left     = 0;
        rx_tick     = 0;
        rx_phase    = 0;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (holdoff_pending) begin
                holdoff_pending = 1'b0;
                i_out_ready <= 1'b0;
                for (hold_n = 0; hold_n < 300; hold_n++) @(negedge i_clk);
            end
            if (rx_left <= 0) begin
                rx_phase = $urandom_range(0, 3);
                rx_left  = $urandom_range(30, 150);
            end
            rx_left--;
            rx_tick++;
            case (rx_phase)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(0, 9) < 7);
                2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= (rx_tick % 3 == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_span typed_sp;
        bit    hold_done;
        bit    pause_done;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_code_point    = '0;
        i_line_end      = 1'b0;
        holdoff_pending = 1'b0;
        mismatches      = 0;
        spans_checked   = 0;
        chars_sent      = 0;
        lines_sent      = 0;
        burst_left      = 0;
        hold_done       = 1'b0;
        pause_done      = 1'b0;
        line_reset();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (opening_rows[i]) begin
            typed_sp            = '0;
            typed_sp.start      = opening_rows[i].s;
            typed_sp.length     = opening_rows[i].l;
            typed_sp.cls        = opening_rows[i].c;
            typed_sp.run_last   = 1'b1;
            typed_sp.line_final = 1'b1;
            drive_char(opening_rows[i].cp, opening_rows[i].le, opening_rows[i].typed, typed_sp);
        end
        wait_drained();

        while (chars_sent < 245) begin
            if (!hold_done && chars_sent >= 70) begin
                holdoff_pending = 1'b1;  // sender keeps going meanwhile
                hold_done       = 1'b1;
            end
            if (!pause_done && chars_sent >= 160) begin
                wait_drained();
                pause_done = 1'b1;
            end
            build_random_line();
            send_line();
        end

        // span limit reached with two spans already closed by the last character
        build_span_limit_line(1);
        send_line();

        wait_drained();
        repeat (30) @(posedge i_clk);
        mismatches += spans_due.size();

        $display("Sent %0d characters in %0d lines, checked %0d spans.",
                 chars_sent, lines_sent, spans_checked);
        $display("Covered keywords, literals, comments, span limit, back-pressure.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #(12 * 1000000);
        $display("Run did not complete in time, %0d spans still due.", spans_due.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
